### rtl/core/interval_throughput_meter_top_assert.svh
// Assertion macros for the interval throughput meter.
`ifndef INTERVAL_THROUGHPUT_METER_TOP_ASSERT_SVH
`define INTERVAL_THROUGHPUT_METER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define ITM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itm assertion failed");

// Antecedent implies consequent in the following cycle
`define ITM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itm assertion failed");

`else

`define ITM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ITM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/itm_pkg.sv
package itm_pkg;

   // Field and state widths
   localparam int TIME_W     = 32;
   localparam int PKT_BITS_W = 20;
   localparam int CNT_W      = 16;
   localparam int BITS_W     = 40;
   localparam int BIT_RATE_W = 48;
   localparam int PKT_RATE_W = 32;
   localparam int BATCH_W    = 16;

   // Products and division
   localparam int NUM_B_W = BITS_W + TIME_W;       // bit count times ticks per second
   localparam int NUM_P_W = CNT_W + TIME_W;        // packet count times ticks per second
   localparam int STEP_W  = $clog2(BIT_RATE_W);

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL = 2'd1;

   // Register reset values
   localparam logic [BATCH_W-1:0] BATCH_SIZE_RESET   = 16'd100;
   localparam logic [TIME_W-1:0]  MAX_INTERVAL_RESET = 32'd1000000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic mul;
      logic sum;
      logic load;
      logic step_bit;
      logic step_pkt;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic close;
   } sts_type;

endpackage

### rtl/core/itm_ctrl.sv
module itm_ctrl
   import itm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic last_step;
   logic out_free;

   assign last_step = (step_ff == STEP_W'(BIT_RATE_W - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.close) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (last_step) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_MUL:  cmd.mul  = 1'b1;
         ST_SUM:  cmd.sum  = 1'b1;
         ST_LOAD: cmd.load = 1'b1;
         ST_DIV: begin
            cmd.step_bit = 1'b1;
            cmd.step_pkt = (step_ff < STEP_W'(PKT_RATE_W));
         end
         ST_OUT:  cmd.out_load = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   // Count division steps; hold the result valid until taken
   assign step_in      = (state_ff == ST_DIV) ? step_ff + 1'b1 : '0;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/itm_datapath.sv
module itm_datapath
   import itm_pkg::*;
#(
   parameter int unsigned TICKS_PER_SECOND = 1000000
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [TIME_W-1:0]     req_arrival_time,
   input  logic [PKT_BITS_W-1:0] req_packet_bits,
   output logic [TIME_W-1:0]     rsp_interval_begin,
   output logic [BIT_RATE_W-1:0] rsp_bit_rate,
   output logic [PKT_RATE_W-1:0] rsp_packet_rate,
   output logic                  rsp_zero_duration,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam logic [TIME_W-1:0] TPS = TIME_W'(TICKS_PER_SECOND);

   // Configuration
   logic [BATCH_W-1:0] batch_size_ff, batch_size_in;
   logic [TIME_W-1:0]  max_interval_ff, max_interval_in;

   // Running interval
   logic [TIME_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BITS_W-1:0] bits_ff, bits_in;

   // Snapshot of the closed interval
   logic [TIME_W-1:0] op_begin_ff;
   logic [TIME_W-1:0] op_dur_ff;
   logic [BITS_W-1:0] op_bits_ff;
   logic [CNT_W-1:0]  op_cnt_ff;

   // Products and dividends
   logic [2*TIME_W-1:0]            prod_lo_ff;
   logic [BITS_W-TIME_W+TIME_W-1:0] prod_hi_ff;
   logic [NUM_P_W-1:0]             prod_pkt_ff;
   logic [NUM_B_W-1:0]             num_b_ff;

   // Division state
   logic [TIME_W-1:0]     rem_b_ff, rem_b_in;
   logic [BIT_RATE_W-1:0] quo_b_ff, quo_b_in;
   logic                  sat_b_ff;
   logic [TIME_W-1:0]     rem_p_ff, rem_p_in;
   logic [PKT_RATE_W-1:0] quo_p_ff, quo_p_in;
   logic                  sat_p_ff;

   // Result word
   logic [TIME_W-1:0]     out_begin_ff;
   logic [BIT_RATE_W-1:0] out_bit_rate_ff;
   logic [PKT_RATE_W-1:0] out_pkt_rate_ff;
   logic                  out_zero_ff;

   logic [TIME_W-1:0] duration;
   logic              close;
   logic [BITS_W:0]   bit_sum;
   logic [TIME_W:0]   trial_b, trial_p;
   logic              ge_b, ge_p;

   // Register writes; other indexes are dropped
   always_comb begin
      batch_size_in   = batch_size_ff;
      max_interval_in = max_interval_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BATCH_SIZE:   batch_size_in   = csr_wdata[BATCH_W-1:0];
            CSR_MAX_INTERVAL: max_interval_in = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Close test against the incoming word
   assign duration  = req_arrival_time - start_ff;
   assign close     = (cnt_ff >= batch_size_ff) || (duration >= max_interval_ff);
   assign sts.close = close;

   // Add the packet, restarting on close; counts saturate
   assign bit_sum = {1'b0, bits_ff} + {{(BITS_W+1-PKT_BITS_W){1'b0}}, req_packet_bits};

   always_comb begin
      start_in = start_ff;
      cnt_in   = cnt_ff;
      bits_in  = bits_ff;
      if (cmd.accept) begin
         if (close) begin
            start_in = req_arrival_time;
            cnt_in   = CNT_W'(1);
            bits_in  = {{(BITS_W-PKT_BITS_W){1'b0}}, req_packet_bits};
         end else begin
            cnt_in  = (&cnt_ff) ? cnt_ff : cnt_ff + 1'b1;
            bits_in = bit_sum[BITS_W] ? {BITS_W{1'b1}} : bit_sum[BITS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff   <= BATCH_SIZE_RESET;
         max_interval_ff <= MAX_INTERVAL_RESET;
         start_ff        <= '0;
         cnt_ff          <= '0;
         bits_ff         <= '0;
      end else begin
         batch_size_ff   <= batch_size_in;
         max_interval_ff <= max_interval_in;
         start_ff        <= start_in;
         cnt_ff          <= cnt_in;
         bits_ff         <= bits_in;
      end
   end

   // Restoring division steps, one quotient bit each
   assign trial_b = {rem_b_ff, quo_b_ff[BIT_RATE_W-1]};
   assign ge_b    = trial_b >= {1'b0, op_dur_ff};
   assign rem_b_in = ge_b ? TIME_W'(trial_b - {1'b0, op_dur_ff}) : trial_b[TIME_W-1:0];
   assign quo_b_in = {quo_b_ff[BIT_RATE_W-2:0], ge_b};

   assign trial_p = {rem_p_ff, quo_p_ff[PKT_RATE_W-1]};
   assign ge_p    = trial_p >= {1'b0, op_dur_ff};
   assign rem_p_in = ge_p ? TIME_W'(trial_p - {1'b0, op_dur_ff}) : trial_p[TIME_W-1:0];
   assign quo_p_in = {quo_p_ff[PKT_RATE_W-2:0], ge_p};

   always_ff @(posedge clock) begin
      // Capture the closing interval
      if (cmd.accept && close) begin
         op_begin_ff <= start_ff;
         op_dur_ff   <= duration;
         op_bits_ff  <= bits_ff;
         op_cnt_ff   <= cnt_ff;
      end
      // Scale by ticks per second
      if (cmd.mul) begin
         prod_lo_ff  <= {{TIME_W{1'b0}}, op_bits_ff[TIME_W-1:0]} * {{TIME_W{1'b0}}, TPS};
         prod_hi_ff  <= {{TIME_W{1'b0}}, op_bits_ff[BITS_W-1:TIME_W]}
                        * {{(BITS_W-TIME_W){1'b0}}, TPS};
         prod_pkt_ff <= {{TIME_W{1'b0}}, op_cnt_ff} * {{CNT_W{1'b0}}, TPS};
      end
      // Join the partial products
      if (cmd.sum) begin
         num_b_ff <= {prod_hi_ff, {TIME_W{1'b0}}}
                     + {{(NUM_B_W-2*TIME_W){1'b0}}, prod_lo_ff};
      end
      // Seed the dividers; a high part not below the divisor means overflow
      if (cmd.load) begin
         rem_b_ff <= {{(TIME_W-(NUM_B_W-BIT_RATE_W)){1'b0}}, num_b_ff[NUM_B_W-1:BIT_RATE_W]};
         quo_b_ff <= num_b_ff[BIT_RATE_W-1:0];
         sat_b_ff <= {{(TIME_W-(NUM_B_W-BIT_RATE_W)){1'b0}}, num_b_ff[NUM_B_W-1:BIT_RATE_W]}
                     >= op_dur_ff;
         rem_p_ff <= {{(TIME_W-(NUM_P_W-PKT_RATE_W)){1'b0}},
                      prod_pkt_ff[NUM_P_W-1:PKT_RATE_W]};
         quo_p_ff <= prod_pkt_ff[PKT_RATE_W-1:0];
         sat_p_ff <= {{(TIME_W-(NUM_P_W-PKT_RATE_W)){1'b0}},
                      prod_pkt_ff[NUM_P_W-1:PKT_RATE_W]} >= op_dur_ff;
      end else begin
         if (cmd.step_bit) begin
            rem_b_ff <= rem_b_in;
            quo_b_ff <= quo_b_in;
         end
         if (cmd.step_pkt) begin
            rem_p_ff <= rem_p_in;
            quo_p_ff <= quo_p_in;
         end
      end
      // Load the result word
      if (cmd.out_load) begin
         out_begin_ff    <= op_begin_ff;
         out_bit_rate_ff <= sat_b_ff ? {BIT_RATE_W{1'b1}} : quo_b_ff;
         out_pkt_rate_ff <= sat_p_ff ? {PKT_RATE_W{1'b1}} : quo_p_ff;
         out_zero_ff     <= (op_dur_ff == '0);
      end
   end

   assign rsp_interval_begin = out_begin_ff;
   assign rsp_bit_rate       = out_bit_rate_ff;
   assign rsp_packet_rate    = out_pkt_rate_ff;
   assign rsp_zero_duration  = out_zero_ff;

endmodule

### rtl/core/interval_throughput_meter_top.sv
// Interval throughput meter. Each accepted word is one packet (arrival tick, length in bits).
// A packet that does not close the current interval is accepted while the block is idle, so such packets
// stream at one per cycle. A packet that closes the interval is accepted and then keeps the
// block busy until its result is loaded: a multiply step, a step to join the partial products,
// a seed step, 48 steps of the bit-serial divider (the bit rate and packet rate dividers run
// side by side on the interval duration) and a step to load the result register. The result
// register holds a finished word while packets continue to arrive; after a further closing
// packet the block stalls before that load only while the word is still not taken. A duration
// of zero gives both rates at their maximum with rsp_zero_duration set. The user must write
// batch_size and max_interval through the csr port while the block is idle; the block does not enforce this.
`include "interval_throughput_meter_top_assert.svh"

module interval_throughput_meter_top
   import itm_pkg::*;
#(
   parameter int unsigned TICKS_PER_SECOND = 1000000
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TIME_W-1:0]     req_arrival_time,
   input  logic [PKT_BITS_W-1:0] req_packet_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TIME_W-1:0]     rsp_interval_begin,
   output logic [BIT_RATE_W-1:0] rsp_bit_rate,
   output logic [PKT_RATE_W-1:0] rsp_packet_rate,
   output logic                  rsp_zero_duration
);

   cmd_type cmd;
   sts_type sts;

   itm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   itm_datapath #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_arrival_time   (req_arrival_time),
      .req_packet_bits    (req_packet_bits),
      .rsp_interval_begin (rsp_interval_begin),
      .rsp_bit_rate       (rsp_bit_rate),
      .rsp_packet_rate    (rsp_packet_rate),
      .rsp_zero_duration  (rsp_zero_duration),
      .cmd                (cmd),
      .sts                (sts)
   );

   // A zero duration word carries both rates at full scale
   `ITM_ASSERT_IMPL(a_zero_sat, clock, reset, rsp_valid && rsp_zero_duration, (&rsp_bit_rate) && (&rsp_packet_rate))
   // A fresh result only follows a busy period
   `ITM_ASSERT_IMPL(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   // A closing packet always takes the block out of idle
   `ITM_ASSERT_NEXT(a_close_busy, clock, reset, req_valid && !req_stall && sts.close, req_stall)

endmodule
